// File: hw/rtl/gamc_pkg.sv
package gamc_pkg;

   localparam int FRACTION_BITS_DEF    = 20;
   localparam int RESTART_DELAY_MS_DEF = 3000;

   localparam int TIME_W     = 32;
   localparam int RATE_W     = 16;
   localparam int DIFF_W     = RATE_W + 1;
   localparam int GAIN_W     = 16;
   localparam int DEAD_W     = 15;
   localparam int SHORT_W    = 10;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int SUM_W      = PROD_W + 1;
   localparam int STEP_W     = 8;
   localparam int STEP_MAX   = 127;
   localparam int BTN_W      = 3;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 32;

   localparam logic [RATE_W-1:0]  OFFSET_Y_RST = '0;
   localparam logic [RATE_W-1:0]  OFFSET_Z_RST = '0;
   localparam logic [DEAD_W-1:0]  DEAD_BAND_RST = 15'd100;
   localparam logic [GAIN_W-1:0]  GAIN_RST = 16'd2996;
   localparam logic [16-1:0]      IDLE_AFTER_RST = 16'd5000;
   localparam logic [SHORT_W-1:0] FREEZE_RST = 10'd150;
   localparam logic [SHORT_W-1:0] SCROLL_GAP_RST = 10'd50;
   localparam logic [16-1:0]      HOLD_RST = 16'd2000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OFFSET_Y      = 3'd0,
      CSR_OFFSET_Z      = 3'd1,
      CSR_DEAD_BAND     = 3'd2,
      CSR_GAIN_Q20      = 3'd3,
      CSR_IDLE_AFTER_MS = 3'd4,
      CSR_FREEZE_MS     = 3'd5,
      CSR_SCROLL_GAP_MS = 3'd6,
      CSR_HOLD_MS       = 3'd7
   } csr_index_type;

endpackage

// File: hw/rtl/gyro_air_mouse_controller.sv
// A request transfer is captured in the input register, and its result is then
// written to the result register; the controller state updates with it.
// Throughput: one sample per cycle; the result register frees the input side,
// so a waiting result only stalls requests once both stages are full.
// Reset (synchronous, active high) restores the register defaults and clears
// all mode, timer and carry state; no clearing pass is needed.
module gyro_air_mouse_controller
   import gamc_pkg::*;
#(
   parameter int FRACTION_BITS    = FRACTION_BITS_DEF,
   parameter int RESTART_DELAY_MS = RESTART_DELAY_MS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // now_ms[31:0], link_up[32], rate_y[48:33], rate_z[64:49], press_left[65],
   // press_right[66], press_middle[67], press_scroll_up[68],
   // press_scroll_down[69], zero fill[71:70]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // buttons_reported[2:0], step_x[10:3], step_y[18:11], scroll_up_step[19],
   // scroll_down_step[20], idle_now[21], sensor_sleep[22], recal_request[23],
   // restart_request[24], zero fill[31:25]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int WHOLE_W = SUM_W - FRACTION_BITS;

   typedef struct packed {
      logic                        neg;
      logic [WHOLE_W-1:0]          whole_mag;
      logic [FRACTION_BITS-1:0]    frac;
   } axis_type;

   function automatic axis_type axis_move(input logic signed [DIFF_W-1:0] e,
                                          input logic signed [FRACTION_BITS:0] carry,
                                          input logic [DEAD_W-1:0] dead,
                                          input logic [GAIN_W-1:0] gain);
      logic signed [DIFF_W-1:0] gs;
      logic signed [PROD_W-1:0] prod;
      logic signed [SUM_W-1:0]  sum;
      logic [DIFF_W-1:0]        emag;
      logic [SUM_W-1:0]         smag;
      axis_type                 res;
      gs   = $signed({1'b0, gain});
      prod = e * gs;
      emag = e[DIFF_W-1] ? DIFF_W'(-e) : DIFF_W'(e);
      sum  = SUM_W'(carry);
      if (emag > {{(DIFF_W-DEAD_W){1'b0}}, dead}) begin
         sum = sum - SUM_W'(prod);
      end
      smag          = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
      res.neg       = sum[SUM_W-1];
      res.whole_mag = smag[SUM_W-1:FRACTION_BITS];
      res.frac      = smag[FRACTION_BITS-1:0];
      return res;
   endfunction

   function automatic logic signed [FRACTION_BITS:0] axis_rem(input axis_type a);
      logic signed [FRACTION_BITS:0] m;
      m = $signed({1'b0, a.frac});
      return a.neg ? -m : m;
   endfunction

   function automatic logic [STEP_W-1:0] axis_step(input axis_type a);
      logic [STEP_W-1:0] m;
      if (a.whole_mag > WHOLE_W'(STEP_MAX)) begin
         m = STEP_W'(STEP_MAX);
      end else begin
         m = a.whole_mag[STEP_W-1:0];
      end
      return a.neg ? STEP_W'(-m) : m;
   endfunction

   logic [RATE_W-1:0]  offset_y_ff, offset_z_ff;
   logic [DEAD_W-1:0]  dead_band_ff;
   logic [GAIN_W-1:0]  gain_ff;
   logic [15:0]        idle_after_ff, hold_ff;
   logic [SHORT_W-1:0] freeze_ff, scroll_gap_ff;

   logic                  req_valid_ff;
   logic [REQ_DATA_W-1:0] req_data_ff;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  advance;

   logic                          idle_ff, idle_in, hold_flag_ff, hold_flag_in;
   logic                          ever_linked_ff, ever_linked_in, down_armed_ff, down_armed_in;
   logic [TIME_W-1:0]             last_act_ff, last_act_in, hold_start_ff, hold_start_in;
   logic [TIME_W-1:0]             freeze_start_ff, freeze_start_in;
   logic [TIME_W-1:0]             scroll_last_ff, scroll_last_in, down_start_ff, down_start_in;
   logic [BTN_W-1:0]              prev_btn_ff, prev_btn_in, held_ff, held_in;
   logic signed [FRACTION_BITS:0] carry_x_ff, carry_x_in, carry_y_ff, carry_y_in;

   logic [TIME_W-1:0]        now;
   logic                     link, pl, pr, pm, psu, psd, any;
   logic [BTN_W-1:0]         cur, rise, fall;
   logic signed [DIFF_W-1:0] ey, ez;
   logic [DIFF_W-1:0]        mag_y, mag_z, lim;
   axis_type                 ax, ay;

   logic [STEP_W-1:0] sx, sy;
   logic              scu, scd, sleep, recal, restart, skip;

   assign now  = req_data_ff[31:0];
   assign link = req_data_ff[32];
   assign ey   = $signed({req_data_ff[48], req_data_ff[48:33]})
               - $signed({offset_y_ff[RATE_W-1], offset_y_ff});
   assign ez   = $signed({req_data_ff[64], req_data_ff[64:49]})
               - $signed({offset_z_ff[RATE_W-1], offset_z_ff});
   assign pl   = req_data_ff[65];
   assign pr   = req_data_ff[66];
   assign pm   = req_data_ff[67];
   assign psu  = req_data_ff[68];
   assign psd  = req_data_ff[69];
   assign any  = pl | pr | pm | psu | psd;
   assign cur  = {pm, pr, pl};

   assign mag_y = ey[DIFF_W-1] ? DIFF_W'(-ey) : DIFF_W'(ey);
   assign mag_z = ez[DIFF_W-1] ? DIFF_W'(-ez) : DIFF_W'(ez);
   assign lim   = {1'b0, dead_band_ff, 1'b0};

   assign ax = axis_move(ez, carry_x_ff, dead_band_ff, gain_ff);
   assign ay = axis_move(ey, carry_y_ff, dead_band_ff, gain_ff);

   assign advance    = req_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~req_valid_ff | advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   always_comb begin
      idle_in         = idle_ff;
      hold_flag_in    = hold_flag_ff;
      ever_linked_in  = ever_linked_ff;
      down_armed_in   = down_armed_ff;
      last_act_in     = last_act_ff;
      hold_start_in   = hold_start_ff;
      freeze_start_in = freeze_start_ff;
      scroll_last_in  = scroll_last_ff;
      down_start_in   = down_start_ff;
      prev_btn_in     = prev_btn_ff;
      held_in         = held_ff;
      carry_x_in      = carry_x_ff;
      carry_y_in      = carry_y_ff;
      sx      = '0;
      sy      = '0;
      scu     = 1'b0;
      scd     = 1'b0;
      sleep   = 1'b0;
      recal   = 1'b0;
      restart = 1'b0;
      skip    = 1'b0;
      rise    = cur & ~prev_btn_ff;
      fall    = ~cur & prev_btn_ff;

      if (!link) begin
         if (ever_linked_ff) begin
            if (!down_armed_ff) begin
               down_armed_in = 1'b1;
               down_start_in = now;
            end else if (now - down_start_ff > TIME_W'(RESTART_DELAY_MS)) begin
               restart = 1'b1;
            end
         end
      end else begin
         ever_linked_in = 1'b1;
         down_armed_in  = 1'b0;
         if (!idle_ff && (now - last_act_ff > {16'd0, idle_after_ff})) begin
            idle_in = 1'b1;
         end
         if (idle_in) begin
            if (mag_z > lim || mag_y > lim || any) begin
               idle_in     = 1'b0;
               last_act_in = now;
            end else begin
               sleep = 1'b1;
            end
         end else begin
            if (any) begin
               last_act_in = now;
            end
            if (pl && pr) begin
               if (!hold_flag_ff) begin
                  hold_flag_in  = 1'b1;
                  hold_start_in = now;
               end else if (now - hold_start_ff >= {16'd0, hold_ff}) begin
                  held_in      = held_ff & 3'b100;
                  carry_x_in   = '0;
                  carry_y_in   = '0;
                  recal        = 1'b1;
                  hold_flag_in = 1'b0;
                  last_act_in  = now;
                  skip         = 1'b1;
               end
            end else begin
               hold_flag_in = 1'b0;
            end
            if (!skip) begin
               if (!hold_flag_in) begin
                  if (rise != '0) begin
                     freeze_start_in = now;
                  end
                  held_in = (held_ff | rise) & ~fall;
               end
               prev_btn_in = cur;
               if (now - freeze_start_in > {22'd0, freeze_ff}) begin
                  carry_x_in = axis_rem(ax);
                  carry_y_in = axis_rem(ay);
                  if (ax.whole_mag != '0 || ay.whole_mag != '0) begin
                     sx          = axis_step(ax);
                     sy          = axis_step(ay);
                     last_act_in = now;
                  end
               end else begin
                  carry_x_in = '0;
                  carry_y_in = '0;
               end
               if ((psu || psd) && (now - scroll_last_ff >= {22'd0, scroll_gap_ff})) begin
                  scu            = psu;
                  scd            = psd;
                  scroll_last_in = now;
               end
            end
         end
      end

      rsp_data_in = {7'd0, restart, recal, sleep, idle_in, scd, scu, sy, sx, held_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_y_ff   <= OFFSET_Y_RST;
         offset_z_ff   <= OFFSET_Z_RST;
         dead_band_ff  <= DEAD_BAND_RST;
         gain_ff       <= GAIN_RST;
         idle_after_ff <= IDLE_AFTER_RST;
         freeze_ff     <= FREEZE_RST;
         scroll_gap_ff <= SCROLL_GAP_RST;
         hold_ff       <= HOLD_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_OFFSET_Y:      offset_y_ff   <= csr_data;
            CSR_OFFSET_Z:      offset_z_ff   <= csr_data;
            CSR_DEAD_BAND:     dead_band_ff  <= csr_data[DEAD_W-1:0];
            CSR_GAIN_Q20:      gain_ff       <= csr_data;
            CSR_IDLE_AFTER_MS: idle_after_ff <= csr_data;
            CSR_FREEZE_MS:     freeze_ff     <= csr_data[SHORT_W-1:0];
            CSR_SCROLL_GAP_MS: scroll_gap_ff <= csr_data[SHORT_W-1:0];
            CSR_HOLD_MS:       hold_ff       <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            req_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_data_ff <= req_tdata;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_ff         <= 1'b0;
         hold_flag_ff    <= 1'b0;
         ever_linked_ff  <= 1'b0;
         down_armed_ff   <= 1'b0;
         last_act_ff     <= '0;
         hold_start_ff   <= '0;
         freeze_start_ff <= '0;
         scroll_last_ff  <= '0;
         down_start_ff   <= '0;
         prev_btn_ff     <= '0;
         held_ff         <= '0;
         carry_x_ff      <= '0;
         carry_y_ff      <= '0;
      end else if (advance) begin
         idle_ff         <= idle_in;
         hold_flag_ff    <= hold_flag_in;
         ever_linked_ff  <= ever_linked_in;
         down_armed_ff   <= down_armed_in;
         last_act_ff     <= last_act_in;
         hold_start_ff   <= hold_start_in;
         freeze_start_ff <= freeze_start_in;
         scroll_last_ff  <= scroll_last_in;
         down_start_ff   <= down_start_in;
         prev_btn_ff     <= prev_btn_in;
         held_ff         <= held_in;
         carry_x_ff      <= carry_x_in;
         carry_y_ff      <= carry_y_in;
      end
   end

endmodule
